>>> rtl/tsfr_pkg.sv
`timescale 1ns / 1ps

package tsfr_pkg;

  localparam int FRAME_LENGTH_DEFAULT = 10;
  localparam int QUEUE_DEPTH          = 2;

  localparam int BYTE_W  = 8;
  localparam int VALUE_W = 16;
  localparam int POS_W   = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [POS_W-1:0] POS_HEADER_FIRST  = 4'd0;
  localparam logic [POS_W-1:0] POS_HEADER_SECOND = 4'd1;
  localparam logic [POS_W-1:0] POS_HEADER_THIRD  = 4'd2;
  localparam logic [POS_W-1:0] POS_FIRST_HIGH    = 4'd3;
  localparam logic [POS_W-1:0] POS_FIRST_LOW     = 4'd4;
  localparam logic [POS_W-1:0] POS_SECOND_HIGH   = 4'd5;
  localparam logic [POS_W-1:0] POS_SECOND_LOW    = 4'd6;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEADER_FIRST  = 3'd0,
    CFG_HEADER_SECOND = 3'd1,
    CFG_HEADER_THIRD  = 3'd2,
    CFG_FIRST_MIN     = 3'd3,
    CFG_FIRST_MAX     = 3'd4,
    CFG_SECOND_MIN    = 3'd5,
    CFG_SECOND_MAX    = 3'd6
  } cfg_index_t;

  localparam logic [BYTE_W-1:0]  RESET_HEADER_FIRST  = 8'd35;
  localparam logic [BYTE_W-1:0]  RESET_HEADER_SECOND = 8'd38;
  localparam logic [BYTE_W-1:0]  RESET_HEADER_THIRD  = 8'd114;
  localparam logic [VALUE_W-1:0] RESET_FIRST_MIN     = 16'd240;
  localparam logic [VALUE_W-1:0] RESET_FIRST_MAX     = 16'd300;
  localparam logic [VALUE_W-1:0] RESET_SECOND_MIN    = 16'd10;
  localparam logic [VALUE_W-1:0] RESET_SECOND_MAX    = 16'd4000;

  typedef struct packed {
    logic [BYTE_W-1:0] first;
    logic [BYTE_W-1:0] second;
    logic [BYTE_W-1:0] third;
  } headers_t;

  typedef struct packed {
    logic [VALUE_W-1:0] first_min;
    logic [VALUE_W-1:0] first_max;
    logic [VALUE_W-1:0] second_min;
    logic [VALUE_W-1:0] second_max;
  } limits_t;

  typedef struct packed {
    logic [VALUE_W-1:0] first_value;
    logic [VALUE_W-1:0] second_value;
  } frame_t;

endpackage

>>> rtl/tsfr_front.sv
`timescale 1ns / 1ps

module tsfr_front #(
  parameter int FRAME_LENGTH = tsfr_pkg::FRAME_LENGTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           accept,
  input  logic [tsfr_pkg::BYTE_W-1:0]    rx_byte,
  input  tsfr_pkg::headers_t             headers,
  output logic                           push,
  output tsfr_pkg::frame_t               push_frame
);

  localparam logic [tsfr_pkg::POS_W-1:0] LAST_POS = tsfr_pkg::POS_W'(FRAME_LENGTH - 1);

  logic [tsfr_pkg::POS_W-1:0]   pos_r, pos_nxt;
  logic [tsfr_pkg::BYTE_W-1:0]  sum_r, sum_nxt;
  logic [tsfr_pkg::VALUE_W-1:0] first_r, first_nxt;
  logic [tsfr_pkg::VALUE_W-1:0] second_r, second_nxt;
  logic                         push_nxt;

  always_comb begin
    pos_nxt    = pos_r;
    sum_nxt    = sum_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    push_nxt   = 1'b0;
    if (accept) begin
      priority if (pos_r >= LAST_POS) begin
        push_nxt = (sum_r == rx_byte);
        pos_nxt  = '0;
        sum_nxt  = '0;
      end else if ((pos_r == tsfr_pkg::POS_HEADER_FIRST  && rx_byte != headers.first)  ||
                   (pos_r == tsfr_pkg::POS_HEADER_SECOND && rx_byte != headers.second) ||
                   (pos_r == tsfr_pkg::POS_HEADER_THIRD  && rx_byte != headers.third)) begin
        pos_nxt = '0;
        sum_nxt = '0;
      end else begin
        sum_nxt = (pos_r == tsfr_pkg::POS_HEADER_FIRST) ? rx_byte : sum_r + rx_byte;
        pos_nxt = pos_r + 1'b1;
        if (pos_r == tsfr_pkg::POS_FIRST_HIGH)  first_nxt  = {rx_byte, first_r[7:0]};
        if (pos_r == tsfr_pkg::POS_FIRST_LOW)   first_nxt  = {first_r[15:8], rx_byte};
        if (pos_r == tsfr_pkg::POS_SECOND_HIGH) second_nxt = {rx_byte, second_r[7:0]};
        if (pos_r == tsfr_pkg::POS_SECOND_LOW)  second_nxt = {second_r[15:8], rx_byte};
      end
    end
  end

  assign push                    = push_nxt;
  assign push_frame.first_value  = first_r;
  assign push_frame.second_value = second_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      sum_r    <= '0;
      first_r  <= '0;
      second_r <= '0;
    end else begin
      pos_r    <= pos_nxt;
      sum_r    <= sum_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
    end
  end

endmodule

>>> rtl/tsfr_queue.sv
`timescale 1ns / 1ps

module tsfr_queue #(
  parameter int DEPTH = tsfr_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  tsfr_pkg::frame_t push_frame,
  input  logic             pop,
  output logic             full,
  output logic             head_valid,
  output tsfr_pkg::frame_t head_frame
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

  tsfr_pkg::frame_t  slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  logic              do_push, do_pop;

  assign full       = (count_r == FULL_COUNT);
  assign head_valid = (count_r != '0);
  assign head_frame = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

>>> rtl/tsfr_back.sv
`timescale 1ns / 1ps

module tsfr_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           head_valid,
  input  tsfr_pkg::frame_t               head_frame,
  input  tsfr_pkg::limits_t              limits,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [tsfr_pkg::VALUE_W-1:0]   out_first_value,
  output logic [tsfr_pkg::VALUE_W-1:0]   out_second_value,
  output logic                           out_in_range
);

  logic                         out_valid_r;
  logic [tsfr_pkg::VALUE_W-1:0] first_r, second_r;
  logic                         range_r;
  logic                         range_nxt;

  assign pop = head_valid && (!out_valid_r || !out_stall);

  assign range_nxt = (head_frame.first_value  >= limits.first_min)  &&
                     (head_frame.first_value  <= limits.first_max)  &&
                     (head_frame.second_value >= limits.second_min) &&
                     (head_frame.second_value <= limits.second_max);

  always_ff @(posedge clk) begin
    if (pop) begin
      first_r  <= head_frame.first_value;
      second_r <= head_frame.second_value;
      range_r  <= range_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_first_value  = first_r;
  assign out_second_value = second_r;
  assign out_in_range     = range_r;

endmodule

>>> rtl/tagged_sensor_frame_receiver.sv
`timescale 1ns / 1ps

// Receives one serial byte a word and looks for frames of FRAME_LENGTH bytes that open
// with three configured header bytes and close with a mod-256 sum of the bytes before
// it. Each frame with a good checksum gives one result word: the big-endian values of
// bytes 3-4 and 5-6 and a flag that both lie inside their inclusive limits. A byte is
// taken every cycle while in_stall is low; the result word follows the checksum byte
// through a two-entry queue and then the output register. in_stall rises only while
// that queue is full, which takes a result side stalled for two frames or more.

module tagged_sensor_frame_receiver #(
  parameter int FRAME_LENGTH = tsfr_pkg::FRAME_LENGTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [tsfr_pkg::BYTE_W-1:0]         in_rx_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [tsfr_pkg::VALUE_W-1:0]        out_first_value,
  output logic [tsfr_pkg::VALUE_W-1:0]        out_second_value,
  output logic                                out_in_range,
  input  logic                                cfg_wr_en,
  input  logic [tsfr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tsfr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  tsfr_pkg::headers_t headers_r;
  tsfr_pkg::limits_t  limits_r;
  tsfr_pkg::frame_t   push_frame, head_frame;
  logic               accept, push, pop, full, head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      headers_r.first   <= tsfr_pkg::RESET_HEADER_FIRST;
      headers_r.second  <= tsfr_pkg::RESET_HEADER_SECOND;
      headers_r.third   <= tsfr_pkg::RESET_HEADER_THIRD;
      limits_r.first_min  <= tsfr_pkg::RESET_FIRST_MIN;
      limits_r.first_max  <= tsfr_pkg::RESET_FIRST_MAX;
      limits_r.second_min <= tsfr_pkg::RESET_SECOND_MIN;
      limits_r.second_max <= tsfr_pkg::RESET_SECOND_MAX;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        tsfr_pkg::CFG_HEADER_FIRST:  headers_r.first  <= cfg_wdata[7:0];
        tsfr_pkg::CFG_HEADER_SECOND: headers_r.second <= cfg_wdata[7:0];
        tsfr_pkg::CFG_HEADER_THIRD:  headers_r.third  <= cfg_wdata[7:0];
        tsfr_pkg::CFG_FIRST_MIN:     limits_r.first_min  <= cfg_wdata;
        tsfr_pkg::CFG_FIRST_MAX:     limits_r.first_max  <= cfg_wdata;
        tsfr_pkg::CFG_SECOND_MIN:    limits_r.second_min <= cfg_wdata;
        tsfr_pkg::CFG_SECOND_MAX:    limits_r.second_max <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_stall = full;
  assign accept   = in_valid && !full;

  tsfr_front #(
    .FRAME_LENGTH(FRAME_LENGTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .rx_byte    (in_rx_byte),
    .headers    (headers_r),
    .push       (push),
    .push_frame (push_frame)
  );

  tsfr_queue #(
    .DEPTH(tsfr_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_frame (push_frame),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head_frame (head_frame)
  );

  tsfr_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (head_valid),
    .head_frame       (head_frame),
    .limits           (limits_r),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_first_value  (out_first_value),
    .out_second_value (out_second_value),
    .out_in_range     (out_in_range)
  );

endmodule

>>> tb/tagged_sensor_frame_receiver_tb.sv
`timescale 1ns / 1ps

module tagged_sensor_frame_receiver_tb;
  import tsfr_pkg::*;

  localparam int FRAME_LEN    = FRAME_LENGTH_DEFAULT;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 200;
  localparam int PHASES       = 8;
  localparam int PHASE_BYTES  = 90;
  localparam int TIMEOUT_NS   = 200_000;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_NONE,
    ROW_RESULT
  } row_kind_t;

  typedef struct packed {
    logic [VALUE_W-1:0] first_value;
    logic [VALUE_W-1:0] second_value;
    logic               in_range;
  } reading_t;

  typedef struct packed {
    logic [BYTE_W-1:0] rx;
    row_kind_t         kind;
    reading_t          typed;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [BYTE_W-1:0] in_rx_byte = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [VALUE_W-1:0] out_first_value;
  logic [VALUE_W-1:0] out_second_value;
  logic out_in_range;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // frame tracker copy of the block
  logic [BYTE_W-1:0]  hdr_first     = RESET_HEADER_FIRST;
  logic [BYTE_W-1:0]  hdr_second    = RESET_HEADER_SECOND;
  logic [BYTE_W-1:0]  hdr_third     = RESET_HEADER_THIRD;
  logic [VALUE_W-1:0] lim_first_min  = RESET_FIRST_MIN;
  logic [VALUE_W-1:0] lim_first_max  = RESET_FIRST_MAX;
  logic [VALUE_W-1:0] lim_second_min = RESET_SECOND_MIN;
  logic [VALUE_W-1:0] lim_second_max = RESET_SECOND_MAX;
  logic [POS_W-1:0]   rx_pos     = '0;
  logic [BYTE_W-1:0]  rx_sum     = '0;
  logic [VALUE_W-1:0] cap_first  = '0;
  logic [VALUE_W-1:0] cap_second = '0;

  reading_t expected_readings[$];
  dir_row_t directed_rows[$];
  int mismatches = 0;
  int bytes_sent = 0;

  bit idle_enabled = 1'b1;
  bit hold_request = 1'b0;
  bit hold_taken = 1'b0;
  int hold_left = 0;
  int burst_left = 0;

  tagged_sensor_frame_receiver #(
    .FRAME_LENGTH(FRAME_LEN)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_rx_byte(in_rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_first_value(out_first_value),
    .out_second_value(out_second_value),
    .out_in_range(out_in_range),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit track_frame_byte(input logic [BYTE_W-1:0] b, output reading_t r);
    bit ok;
    r = '0;
    if (rx_pos >= POS_W'(FRAME_LEN - 1)) begin
      ok = (rx_sum == b);
      rx_pos = '0;
      rx_sum = '0;
      if (!ok) return 1'b0;
      r.first_value  = cap_first;
      r.second_value = cap_second;
      r.in_range = (cap_first >= lim_first_min) && (cap_first <= lim_first_max) &&
                   (cap_second >= lim_second_min) && (cap_second <= lim_second_max);
      return 1'b1;
    end
    if ((rx_pos == POS_HEADER_FIRST && b != hdr_first) ||
        (rx_pos == POS_HEADER_SECOND && b != hdr_second) ||
        (rx_pos == POS_HEADER_THIRD && b != hdr_third)) begin
      rx_pos = '0;
      rx_sum = '0;
      return 1'b0;
    end
    rx_sum = (rx_pos == POS_HEADER_FIRST) ? b : rx_sum + b;
    case (rx_pos)
      POS_FIRST_HIGH:  cap_first[15:8]  = b;
      POS_FIRST_LOW:   cap_first[7:0]   = b;
      POS_SECOND_HIGH: cap_second[15:8] = b;
      POS_SECOND_LOW:  cap_second[7:0]  = b;
      default: ;
    endcase
    rx_pos = rx_pos + 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value(input logic [VALUE_W-1:0] lo,
                                                    input logic [VALUE_W-1:0] hi);
    case ($urandom_range(0, 6))
      0: return lo;
      1: return hi;
      2: return lo - 1'b1;
      3: return hi + 1'b1;
      4, 5: return VALUE_W'($urandom_range(lo, hi));
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  function automatic logic [2*VALUE_W-1:0] pick_limits();
    logic [VALUE_W-1:0] a;
    logic [VALUE_W-1:0] b;
    a = VALUE_W'($urandom);
    b = VALUE_W'($urandom);
    if (a > b && $urandom_range(0, 3) != 0) return {b, a};
    return {a, b};
  endfunction

  task automatic add_row(input logic [BYTE_W-1:0] rx, input row_kind_t kind,
                         input logic [VALUE_W-1:0] fv = '0,
                         input logic [VALUE_W-1:0] sv = '0, input logic ir = 1'b0);
    dir_row_t row;
    row.rx = rx;
    row.kind = kind;
    row.typed.first_value = fv;
    row.typed.second_value = sv;
    row.typed.in_range = ir;
    directed_rows.push_back(row);
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_byte(input logic [BYTE_W-1:0] b, input row_kind_t kind,
                           input reading_t typed);
    int gap;
    bit made;
    reading_t predicted;
    gap = (idle_enabled && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    made = track_frame_byte(b, predicted);
    case (kind)
      ROW_PREDICT: if (made) expected_readings.push_back(predicted);
      ROW_RESULT:  expected_readings.push_back(typed);
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic send_frame(input bit bad_sum, input int break_at, input int cut);
    logic [BYTE_W-1:0] frame [FRAME_LEN];
    logic [VALUE_W-1:0] v1;
    logic [VALUE_W-1:0] v2;
    logic [BYTE_W-1:0] sum;
    v1 = pick_value(lim_first_min, lim_first_max);
    v2 = pick_value(lim_second_min, lim_second_max);
    frame[0] = hdr_first;
    frame[1] = hdr_second;
    frame[2] = hdr_third;
    frame[3] = v1[15:8];
    frame[4] = v1[7:0];
    frame[5] = v2[15:8];
    frame[6] = v2[7:0];
    for (int i = 7; i < FRAME_LEN - 1; i++) frame[i] = BYTE_W'($urandom);
    if (break_at > 0) frame[break_at] = frame[break_at] ^ BYTE_W'($urandom_range(1, 255));
    sum = '0;
    for (int i = 0; i < FRAME_LEN - 1; i++) sum = sum + frame[i];
    frame[FRAME_LEN-1] = bad_sum ? sum ^ BYTE_W'($urandom_range(1, 255)) : sum;
    for (int i = 0; i < cut; i++) send_byte(frame[i], ROW_PREDICT, '0);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_HEADER_FIRST:  hdr_first      = data[BYTE_W-1:0];
      CFG_HEADER_SECOND: hdr_second     = data[BYTE_W-1:0];
      CFG_HEADER_THIRD:  hdr_third      = data[BYTE_W-1:0];
      CFG_FIRST_MIN:     lim_first_min  = data[VALUE_W-1:0];
      CFG_FIRST_MAX:     lim_first_max  = data[VALUE_W-1:0];
      CFG_SECOND_MIN:    lim_second_min = data[VALUE_W-1:0];
      CFG_SECOND_MAX:    lim_second_max = data[VALUE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic configure(input logic [BYTE_W-1:0] h1, input logic [BYTE_W-1:0] h2,
                           input logic [BYTE_W-1:0] h3, input logic [2*VALUE_W-1:0] lim1,
                           input logic [2*VALUE_W-1:0] lim2);
    // upper bits of the header words are junk and must be masked off
    write_register(CFG_HEADER_FIRST, {8'($urandom), h1});
    write_register(CFG_HEADER_SECOND, {8'($urandom), h2});
    write_register(CFG_HEADER_THIRD, {8'($urandom), h3});
    write_register(CFG_FIRST_MIN, lim1[2*VALUE_W-1:VALUE_W]);
    write_register(CFG_FIRST_MAX, lim1[VALUE_W-1:0]);
    write_register(CFG_SECOND_MIN, lim2[2*VALUE_W-1:VALUE_W]);
    write_register(CFG_SECOND_MAX, lim2[VALUE_W-1:0]);
    write_register(CFG_SPARE, CFG_DATA_W'($urandom));
    cfg_wr_en <= 1'b0;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic check_field(input string field, input logic [VALUE_W-1:0] want,
                             input logic [VALUE_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  always @(negedge clk) begin
    if (hold_request && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (burst_left > 0) begin
      burst_left--;
      out_stall <= 1'b1;
    end else if (idle_enabled && $urandom_range(0, 3) == 0) begin
      burst_left = $urandom_range(1, 3) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    reading_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_readings.size() == 0) begin
        $error("unexpected word: first_value %0d, second_value %0d, in_range %0d",
               out_first_value, out_second_value, out_in_range);
        mismatches++;
      end else begin
        want = expected_readings.pop_front();
        check_field("first_value", want.first_value, out_first_value);
        check_field("second_value", want.second_value, out_second_value);
        check_field("in_range", VALUE_W'(want.in_range), VALUE_W'(out_in_range));
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("** tagged_sensor_frame_receiver: FAILED **");
    $finish;
  end

  initial begin
    logic [2*VALUE_W-1:0] lim1;
    logic [2*VALUE_W-1:0] lim2;
    logic [VALUE_W-1:0] pin1;
    logic [VALUE_W-1:0] pin2;
    int phase_start;
    int pick;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // header mismatches at each of the three positions
    add_row(8'h00, ROW_NONE);
    add_row(RESET_HEADER_FIRST, ROW_PREDICT); add_row(RESET_HEADER_FIRST, ROW_NONE);
    add_row(RESET_HEADER_FIRST, ROW_PREDICT); add_row(RESET_HEADER_SECOND, ROW_PREDICT);
    add_row(8'h00, ROW_NONE);
    // good frame at reset limits, 256 and 100
    add_row(RESET_HEADER_FIRST, ROW_PREDICT); add_row(RESET_HEADER_SECOND, ROW_PREDICT);
    add_row(RESET_HEADER_THIRD, ROW_PREDICT);
    add_row(8'h01, ROW_PREDICT); add_row(8'h00, ROW_PREDICT);
    add_row(8'h00, ROW_PREDICT); add_row(8'h64, ROW_PREDICT);
    add_row(8'h00, ROW_PREDICT); add_row(8'h00, ROW_PREDICT);
    add_row(8'h20, ROW_RESULT, 16'd256, 16'd100, 1'b1);
    // extreme values, out of range
    add_row(RESET_HEADER_FIRST, ROW_PREDICT); add_row(RESET_HEADER_SECOND, ROW_PREDICT);
    add_row(RESET_HEADER_THIRD, ROW_PREDICT);
    add_row(8'hFF, ROW_PREDICT); add_row(8'hFF, ROW_PREDICT);
    add_row(8'h00, ROW_PREDICT); add_row(8'h00, ROW_PREDICT);
    add_row(8'h00, ROW_PREDICT); add_row(8'h00, ROW_PREDICT);
    add_row(8'hB9, ROW_RESULT, 16'hFFFF, 16'h0000, 1'b0);
    // bad checksum, dropped
    add_row(RESET_HEADER_FIRST, ROW_PREDICT); add_row(RESET_HEADER_SECOND, ROW_PREDICT);
    add_row(RESET_HEADER_THIRD, ROW_PREDICT);
    add_row(8'h01, ROW_PREDICT); add_row(8'h2C, ROW_PREDICT);
    add_row(8'h0F, ROW_PREDICT); add_row(8'hA0, ROW_PREDICT);
    add_row(8'h55, ROW_PREDICT); add_row(8'hAA, ROW_PREDICT);
    add_row(8'h97, ROW_NONE);

    foreach (directed_rows[i])
      send_byte(directed_rows[i].rx, directed_rows[i].kind, directed_rows[i].typed);

    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      case (phase)
        1: configure(8'h00, 8'h00, 8'h00, {16'h0000, 16'hFFFF}, {16'h0000, 16'hFFFF});
        // minimum above maximum, nothing in range
        2: configure(8'hFF, 8'hFF, 8'hFF, {16'hFFFF, 16'h0000}, {16'hFFFF, 16'h0000});
        3: begin
          pin1 = VALUE_W'($urandom);
          pin2 = VALUE_W'($urandom);
          configure(8'($urandom), 8'($urandom), 8'($urandom), {pin1, pin1}, {pin2, pin2});
        end
        PHASES - 1: configure(RESET_HEADER_FIRST, RESET_HEADER_SECOND, RESET_HEADER_THIRD,
                              {RESET_FIRST_MIN, RESET_FIRST_MAX},
                              {RESET_SECOND_MIN, RESET_SECOND_MAX});
        default: begin
          lim1 = pick_limits();
          lim2 = pick_limits();
          configure(8'($urandom), 8'($urandom), 8'($urandom), lim1, lim2);
        end
      endcase
      if (phase == 2) hold_request = 1'b1;
      if (phase == PHASES - 1) idle_enabled = 1'b0;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) send_frame(1'b0, 0, FRAME_LEN);
        else if (pick < 80) send_frame(1'b1, 0, FRAME_LEN);
        else if (pick < 88) send_frame(1'b0, 0, $urandom_range(3, FRAME_LEN - 1));
        else if (pick < 94) send_frame(1'b0, $urandom_range(1, 2), FRAME_LEN);
        else repeat ($urandom_range(1, 4)) send_byte(8'($urandom), ROW_PREDICT, '0);
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("** tagged_sensor_frame_receiver: PASSED **");
    end else begin
      $display("** tagged_sensor_frame_receiver: FAILED **");
    end
    $finish;
  end

endmodule
